// ===== sv/gfsp_pkg.sv =====
// Shared types and constants of the genotype field stream parser.
package gfsp_pkg;

  // Expected sample count is clamped to this many samples per line
  localparam int unsigned MAX_SAMPLES = 4096;

  // Fixed field widths
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned NUM_W   = 12;
  localparam int unsigned GTIX_W  = 6;
  localparam int unsigned SUBP_W  = 7;
  localparam int unsigned CFG_IX_W = 2;

  localparam logic [CNT_W-1:0]  MAX_EXPECTED = CNT_W'(MAX_SAMPLES);
  localparam logic [CNT_W-1:0]  CNT_SAT      = '1;
  localparam logic [NUM_W-1:0]  NUM_SAT      = '1;
  localparam logic [SUBP_W-1:0] SUBP_SAT     = '1;

  // Configuration register indexes
  localparam logic [CFG_IX_W-1:0] REG_GT_FIELD_INDEX = CFG_IX_W'(0);
  localparam logic [CFG_IX_W-1:0] REG_SAMPLE_COUNT   = CFG_IX_W'(1);

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  // Allele codes; AL_OTHER is internal only
  localparam logic [1:0] AL_REF   = 2'd0;
  localparam logic [1:0] AL_ALT   = 2'd1;
  localparam logic [1:0] AL_MISS  = 2'd2;
  localparam logic [1:0] AL_OTHER = 2'd3;

  // Allele value: bit 2 negative, bits 1:0 magnitude 0, 1 or 2-and-up
  localparam logic [1:0] MAG_ZERO = 2'd0;
  localparam logic [1:0] MAG_ONE  = 2'd1;
  localparam logic [1:0] MAG_BIG  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EXCESS   = 2'd1,
    ST_MISMATCH = 2'd2
  } gfsp_status_e;

  typedef enum logic [2:0] {
    PH_WS1   = 3'd0,
    PH_SIGN1 = 3'd1,
    PH_DIG1  = 3'd2,
    PH_WS2   = 3'd3,
    PH_SIGN2 = 3'd4,
    PH_DIG2  = 3'd5,
    PH_DONE  = 3'd6,
    PH_FAIL  = 3'd7
  } gfsp_phase_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       line_end;
  } gfsp_in_t;

  typedef struct packed {
    logic [1:0]       first_allele;
    logic [1:0]       second_allele;
    logic             phased;
    logic             sample_present;
    logic [NUM_W-1:0] sample_number;
    logic             line_done;
    gfsp_status_e     status;
  } gfsp_out_t;

endpackage

// ===== sv/genotype_field_stream_parser.sv =====
// Genotype field stream parser: per-byte column/subfield tracking and GT pair parsing.
//
// Accepts one text byte per clock cycle while not stalled. Each byte updates the column
// state (subfield position, token length, genotype parse phase and allele values),
// and a tab or line-end byte loads at most one result into the output register,
// or into the skid stage while the output register holds a stalled result.
// A one-entry skid stage behind the output register lets input continue while
// a result waits; input stalls only once both hold a result. No memories, no
// start-up pass: the block takes bytes right after reset. Configuration writes
// are always ready.
module genotype_field_stream_parser
  import gfsp_pkg::*;
#(
  parameter int unsigned TOKEN_CAP = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // byte input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gfsp_in_t            in_data_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gfsp_out_t           out_data_o,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_IX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]    cfg_data_i
);

  localparam int unsigned TOK_W = $clog2(TOKEN_CAP);
  localparam logic [TOK_W-1:0] TOK_LIMIT = TOK_W'(TOKEN_CAP - 1);

  // Digit accumulation on the saturating allele value
  function automatic logic [2:0] add_digit(input logic [2:0] v, input logic [7:0] d);
    logic [1:0] mag;
    begin
      if (v[1:0] == MAG_ZERO) begin
        mag = (d == 8'd0) ? MAG_ZERO : ((d == 8'd1) ? MAG_ONE : MAG_BIG);
      end else begin
        mag = MAG_BIG;
      end
      add_digit = {v[2], mag};
    end
  endfunction

  // Allele value to code: 0, +1, -1 (missing), other
  function automatic logic [1:0] classify(input logic [2:0] v);
    logic [1:0] code;
    begin
      if (v[1:0] == MAG_ZERO) begin
        code = AL_REF;
      end else if (v[1:0] == MAG_ONE) begin
        code = v[2] ? AL_MISS : AL_ALT;
      end else begin
        code = AL_OTHER;
      end
      classify = code;
    end
  endfunction

  // Configuration registers
  logic [GTIX_W-1:0] gt_idx_q;
  logic [CNT_W-1:0]  smp_cnt_q;

  // Column and line state
  gfsp_phase_e       phase_q, phase_d;
  logic [SUBP_W-1:0] subpos_q, subpos_d;
  logic [TOK_W-1:0]  toklen_q, toklen_d;
  logic [2:0]        first_q, first_d;
  logic [2:0]        second_q, second_d;
  logic              slash_q, slash_d;
  logic              gt_seen_q, gt_seen_d;
  logic [CNT_W-1:0]  samples_q, samples_d;

  // Output register and skid stage
  logic      out_vld_q, skid_vld_q;
  gfsp_out_t out_q, skid_q;

  logic      accept;
  logic      res_vld;
  gfsp_out_t res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_vld_q;
  assign accept      = in_valid_i && !skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Per-byte state update and result formation
  always_comb begin
    logic [7:0]       b;
    logic [7:0]       d;
    logic             dig;
    logic             sgn;
    logic             spc;
    logic             finish;
    logic             ok;
    logic [1:0]       a1;
    logic [1:0]       a2;
    logic [CNT_W-1:0] expected;

    b   = in_data_i.char_byte;
    d   = b - CH_ZERO;
    dig = (d <= 8'd9);
    sgn = (b == CH_PLUS) || (b == CH_MINUS);
    spc = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    expected = (smp_cnt_q > MAX_EXPECTED) ? MAX_EXPECTED : smp_cnt_q;
    ok  = 1'b0;
    a1  = AL_MISS;
    a2  = AL_MISS;

    phase_d   = phase_q;
    subpos_d  = subpos_q;
    toklen_d  = toklen_q;
    first_d   = first_q;
    second_d  = second_q;
    slash_d   = slash_q;
    gt_seen_d = gt_seen_q;
    samples_d = samples_q;

    res_vld            = 1'b0;
    res.first_allele   = AL_MISS;
    res.second_allele  = AL_MISS;
    res.phased         = 1'b0;
    res.sample_present = 1'b0;
    res.sample_number  = '0;
    res.line_done      = in_data_i.line_end;
    res.status         = ST_OK;

    if (subpos_q == SUBP_W'(gt_idx_q)) begin
      gt_seen_d = 1'b1;
    end

    // Byte within the token cap
    if ((b != CH_TAB) && (toklen_q < TOK_LIMIT)) begin
      toklen_d = toklen_q + 1'b1;
      if (b == CH_COLON) begin
        if (subpos_q != SUBP_SAT) begin
          subpos_d = subpos_q + 1'b1;
        end
        if (subpos_d == SUBP_W'(gt_idx_q)) begin
          gt_seen_d = 1'b1;
        end
      end else if (subpos_q == SUBP_W'(gt_idx_q)) begin
        // Genotype pair parse step
        unique case (phase_q)
          PH_WS1: begin
            if (spc) begin
            end else if (sgn) begin
              first_d = (b == CH_MINUS) ? 3'b100 : 3'b000;
              phase_d = PH_SIGN1;
            end else if (dig) begin
              first_d = add_digit(3'b000, d);
              phase_d = PH_DIG1;
            end else begin
              phase_d = PH_FAIL;
            end
          end
          PH_SIGN1: begin
            if (dig) begin
              first_d = add_digit(first_q, d);
              phase_d = PH_DIG1;
            end else begin
              phase_d = PH_FAIL;
            end
          end
          PH_DIG1: begin
            if (dig) begin
              first_d = add_digit(first_q, d);
            end else if (b == CH_PIPE) begin
              slash_d = 1'b0;
              phase_d = PH_WS2;
            end else if (b == CH_SLASH) begin
              slash_d = 1'b1;
              phase_d = PH_WS2;
            end else begin
              phase_d = PH_FAIL;
            end
          end
          PH_WS2: begin
            if (spc) begin
            end else if (sgn) begin
              second_d = (b == CH_MINUS) ? 3'b100 : 3'b000;
              phase_d  = PH_SIGN2;
            end else if (dig) begin
              second_d = add_digit(3'b000, d);
              phase_d  = PH_DIG2;
            end else begin
              phase_d = PH_FAIL;
            end
          end
          PH_SIGN2: begin
            if (dig) begin
              second_d = add_digit(second_q, d);
              phase_d  = PH_DIG2;
            end else begin
              phase_d = PH_FAIL;
            end
          end
          PH_DIG2: begin
            if (dig) begin
              second_d = add_digit(second_q, d);
            end else begin
              phase_d = PH_DONE;
            end
          end
          PH_DONE, PH_FAIL: begin
          end
          default: begin
          end
        endcase
      end
    end

    finish = (b == CH_TAB) || in_data_i.line_end;

    // Column end: emit a seen GT sample or a line-end result, then reset column state
    if (finish) begin
      if (gt_seen_d) begin
        ok = (phase_d == PH_DIG2) || (phase_d == PH_DONE);
        a1 = classify(first_d);
        a2 = classify(second_d);
        res.sample_present = 1'b1;
        if (!ok) begin
          res.phased = 1'b1;
        end else begin
          res.phased = !slash_d;
          if ((a1 != AL_OTHER) && (a2 != AL_OTHER)) begin
            res.first_allele  = a1;
            res.second_allele = a2;
          end
        end
        res.sample_number = (samples_q > CNT_W'(NUM_SAT)) ? NUM_SAT : samples_q[NUM_W-1:0];
        if (samples_q >= expected) begin
          res.status = ST_EXCESS;
        end
        if (samples_q != CNT_SAT) begin
          samples_d = samples_q + 1'b1;
        end
        res_vld = 1'b1;
      end

      if (in_data_i.line_end) begin
        if (samples_d != expected) begin
          res.status = ST_MISMATCH;
        end
        samples_d = '0;
        res_vld   = 1'b1;
      end

      phase_d   = PH_WS1;
      subpos_d  = '0;
      toklen_d  = '0;
      first_d   = '0;
      second_d  = '0;
      slash_d   = 1'b0;
      gt_seen_d = 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_idx_q  <= '0;
      smp_cnt_q <= CNT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_GT_FIELD_INDEX) begin
        gt_idx_q <= cfg_data_i[GTIX_W-1:0];
      end else if (cfg_index_i == REG_SAMPLE_COUNT) begin
        smp_cnt_q <= cfg_data_i;
      end
    end
  end

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WS1;
      subpos_q  <= '0;
      toklen_q  <= '0;
      first_q   <= '0;
      second_q  <= '0;
      slash_q   <= 1'b0;
      gt_seen_q <= 1'b0;
      samples_q <= '0;
    end else if (accept) begin
      phase_q   <= phase_d;
      subpos_q  <= subpos_d;
      toklen_q  <= toklen_d;
      first_q   <= first_d;
      second_q  <= second_d;
      slash_q   <= slash_d;
      gt_seen_q <= gt_seen_d;
      samples_q <= samples_d;
    end
  end

  // Output register with one-entry skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || !out_stall_i) begin
      out_vld_q  <= skid_vld_q || (accept && res_vld);
      skid_vld_q <= 1'b0;
    end else if (accept && res_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || !out_stall_i) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (accept && res_vld) begin
      skid_q <= res;
    end
  end

endmodule
